FILE: rtl/jgip_pkg.sv
// ----------------------------------------------------------------------------
// jgip_pkg
// Types and constants shared by the jittered grid instance placer.
// ----------------------------------------------------------------------------
package jgip_pkg;

  localparam int MAX_SIDE_DEF = 255;
  localparam int MAX_CAP_DEF  = 65536;

  localparam logic [13:0] SEED_MUL  = 14'd9176;
  localparam logic [31:0] HASH_XOR  = 32'd61;
  localparam logic [31:0] HASH_MUL  = 32'h27d4eb2d;
  localparam logic [19:0] POS_MUL   = 20'd768000;
  localparam logic [12:0] JIT_MUL   = 13'd4800;
  localparam logic [23:0] JIT_MID   = 24'h800000;
  localparam logic [31:0] ROT_LO    = 32'h487ED511;
  localparam logic [21:0] POS_LIMIT = 22'd1200000;
  localparam logic [16:0] CAP_RESET = 17'd4096;

  localparam int QBITS = 29;
  localparam int DEN_W = 32;
  localparam int NUM_W = 55;

  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEED_A, ST_SEED_B, ST_SEED_C,
    ST_HASH_A, ST_HASH_B, ST_HASH_C,
    ST_SC_A, ST_SC_B, ST_ROT_A, ST_ROT_B,
    ST_AX_A, ST_AX_B, ST_AX_C, ST_AX_D, ST_AX_E, ST_AX_F, ST_AX_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_op_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QBITS-1:0] quo;
  } div_rsp_t;

endpackage

FILE: rtl/jgip_if.sv
// ----------------------------------------------------------------------------
// jgip_if
// Valid/ready channels for cell items and placement items.
// ----------------------------------------------------------------------------
interface jgip_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  type_index;
  logic [7:0]  side;
  logic [7:0]  cell_x;
  logic [7:0]  cell_z;
  logic [17:0] min_scale;
  logic [17:0] max_scale;

  modport source (output valid, type_index, side, cell_x, cell_z, min_scale, max_scale,
                  input ready);
  modport sink (input valid, type_index, side, cell_x, cell_z, min_scale, max_scale,
                output ready);
endinterface

interface jgip_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [15:0]        instance_index;
  logic signed [21:0] pos_x;
  logic signed [21:0] pos_z;
  logic [17:0]        scale;
  logic [18:0]        rotation;

  modport source (output valid, accepted, instance_index, pos_x, pos_z, scale, rotation,
                  input ready);
  modport sink (input valid, accepted, instance_index, pos_x, pos_z, scale, rotation,
                output ready);
endinterface

FILE: rtl/jgip_mul.sv
// ----------------------------------------------------------------------------
// jgip_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module jgip_mul (
  input  logic             clk,
  input  jgip_pkg::mul_op_t op,
  output logic [63:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(op.a) * 64'(op.b);
  end

endmodule

FILE: rtl/jgip_div.sv
// ----------------------------------------------------------------------------
// jgip_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jgip_div (
  input  logic               clk,
  input  logic               rst,
  input  jgip_pkg::div_req_t req,
  output jgip_pkg::div_rsp_t rsp
);

  localparam int QB   = jgip_pkg::QBITS;
  localparam int DW   = jgip_pkg::DEN_W;
  localparam int NW   = jgip_pkg::NUM_W;
  localparam int CW   = $clog2(QB + 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [QB-1:0] nsh;
  logic [QB-1:0] quo;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem, nsh[QB-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= DW'(req.num[NW-1:QB]);
      nsh <= req.num[QB-1:0];
      den <= req.den;
      cnt <= CW'(QB);
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      nsh <= {nsh[QB-2:0], 1'b0};
      quo <= {quo[QB-2:0], ge};
      cnt <= cnt - CW'(1);
    end
  end

  assign rsp = {done, quo};

endmodule

FILE: rtl/jgip_ctrl.sv
// ----------------------------------------------------------------------------
// jgip_ctrl
// Sequencer and datapath registers: seed, hashes, scale, rotation, positions.
// ----------------------------------------------------------------------------
module jgip_ctrl #(
  parameter int MAX_SIDE     = jgip_pkg::MAX_SIDE_DEF,
  parameter int MAX_CAPACITY = jgip_pkg::MAX_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [16:0] capacity,
  jgip_in_if.sink     in_ch,
  jgip_out_if.source  out_ch
);

  jgip_pkg::state_t   state, state_next;
  jgip_pkg::mul_op_t  mop;
  jgip_pkg::div_req_t dreq;
  jgip_pkg::div_rsp_t drsp;
  logic [63:0]        prod;

  logic [7:0]  type_r, side_r, s_r, cx_r, cz_r;
  logic [17:0] smin_r, smax_r;
  logic        full_r;
  logic [15:0] idx_r;
  logic [16:0] count;
  logic [31:0] seed, t0, hv;
  logic [1:0]  k;
  logic        ax;
  logic [23:0] h_r [4];
  logic [17:0] scale_r;
  logic [18:0] rot_r;
  logic signed [21:0] posx_r, posz_r;
  logic [37:0] m2;
  logic [43:0] jm;
  logic        nneg;

  logic        in_acc, full_c, out_free;
  logic [7:0]  s_c;
  logic [31:0] v0, v1, v2, v3, v4;
  logic [7:0]  c_sel;
  logic [23:0] h_sel;
  logic signed [10:0] a_c;
  logic [9:0]  a_mag;
  logic signed [24:0] hdev;
  logic [23:0] hdev_mag;
  logic [7:0]  sm1;
  logic signed [18:0] d_c;
  logic [17:0] d_mag;
  logic signed [43:0] sc_sum;
  logic [59:0] rsum;
  logic [26:0] hr6;
  logic signed [56:0] term1, term2, num_s;
  logic [56:0] num_mag;
  logic [21:0] q_sat;

  jgip_mul u_mul (.clk(clk), .op(mop), .prod(prod));
  jgip_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ch.ready = (state == jgip_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;

  assign full_c = (count >= capacity) || (21'(count) >= 21'(MAX_CAPACITY));

  always_comb begin
    if (in_ch.side == 8'd0) s_c = 8'd1;
    else if (12'(in_ch.side) > 12'(MAX_SIDE)) s_c = 8'(MAX_SIDE);
    else s_c = in_ch.side;
  end

  // hash pre-mix
  always_comb begin
    v0 = (k == 2'd3) ? seed : seed + (seed << 1) + 32'(k);
    v1 = (v0 ^ jgip_pkg::HASH_XOR) ^ (v0 >> 16);
    v2 = v1 + (v1 << 3);
    v3 = v2 ^ (v2 >> 4);
    v4 = prod[31:0] ^ (prod[31:0] >> 15);
  end

  // axis terms
  always_comb begin
    c_sel    = ax ? cz_r : cx_r;
    h_sel    = ax ? h_r[1] : h_r[0];
    a_c      = $signed({2'b00, c_sel, 1'b0}) - $signed({3'b000, s_r}) + 11'sd1;
    a_mag    = a_c[10] ? 10'(-a_c) : a_c[9:0];
    hdev     = $signed({1'b0, h_sel}) - $signed({1'b0, jgip_pkg::JIT_MID});
    hdev_mag = hdev[24] ? 24'(-hdev) : hdev[23:0];
    sm1      = (s_r == 8'd1) ? 8'd1 : s_r - 8'd1;
    term1    = (s_r == 8'd1) ? 57'sd0
             : (a_c[10] ? -$signed({3'b000, m2, 16'b0}) : $signed({3'b000, m2, 16'b0}));
    term2    = hdev[24] ? -$signed({13'b0, jm}) : $signed({13'b0, jm});
    num_s    = term1 + term2;
    num_mag  = num_s[56] ? 57'(-num_s) : num_s;
    q_sat    = (drsp.quo > 29'(jgip_pkg::POS_LIMIT)) ? jgip_pkg::POS_LIMIT : drsp.quo[21:0];
  end

  // scale and rotation terms
  always_comb begin
    d_c    = $signed({1'b0, smax_r}) - $signed({1'b0, smin_r});
    d_mag  = d_c[18] ? 18'(-d_c) : d_c[17:0];
    sc_sum = d_c[18] ? $signed({2'b00, smin_r, 24'b0}) - $signed({2'b00, prod[41:0]})
                     : $signed({2'b00, smin_r, 24'b0}) + $signed({2'b00, prod[41:0]});
    hr6    = {h_r[3], 2'b00} + {1'b0, h_r[3], 1'b0};
    rsum   = prod[59:0] + {1'b0, hr6, 32'b0};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      jgip_pkg::ST_IDLE:   if (in_acc) state_next = full_c ? jgip_pkg::ST_DONE
                                                           : jgip_pkg::ST_SEED_A;
      jgip_pkg::ST_SEED_A: state_next = jgip_pkg::ST_SEED_B;
      jgip_pkg::ST_SEED_B: state_next = jgip_pkg::ST_SEED_C;
      jgip_pkg::ST_SEED_C: state_next = jgip_pkg::ST_HASH_A;
      jgip_pkg::ST_HASH_A: state_next = jgip_pkg::ST_HASH_B;
      jgip_pkg::ST_HASH_B: state_next = jgip_pkg::ST_HASH_C;
      jgip_pkg::ST_HASH_C: state_next = (k == 2'd3) ? jgip_pkg::ST_SC_A : jgip_pkg::ST_HASH_A;
      jgip_pkg::ST_SC_A:   state_next = jgip_pkg::ST_SC_B;
      jgip_pkg::ST_SC_B:   state_next = jgip_pkg::ST_ROT_A;
      jgip_pkg::ST_ROT_A:  state_next = jgip_pkg::ST_ROT_B;
      jgip_pkg::ST_ROT_B:  state_next = jgip_pkg::ST_AX_A;
      jgip_pkg::ST_AX_A:   state_next = jgip_pkg::ST_AX_B;
      jgip_pkg::ST_AX_B:   state_next = jgip_pkg::ST_AX_C;
      jgip_pkg::ST_AX_C:   state_next = jgip_pkg::ST_AX_D;
      jgip_pkg::ST_AX_D:   state_next = jgip_pkg::ST_AX_E;
      jgip_pkg::ST_AX_E:   state_next = jgip_pkg::ST_AX_F;
      jgip_pkg::ST_AX_F:   state_next = jgip_pkg::ST_AX_DIV;
      jgip_pkg::ST_AX_DIV: if (drsp.done) state_next = ax ? jgip_pkg::ST_DONE
                                                          : jgip_pkg::ST_AX_A;
      jgip_pkg::ST_DONE:   if (out_free) state_next = jgip_pkg::ST_IDLE;
      default:             state_next = jgip_pkg::ST_IDLE;
    endcase
  end

  // unit operands
  always_comb begin
    mop        = '0;
    dreq.start = 1'b0;
    dreq.num   = num_mag[jgip_pkg::NUM_W-1:0];
    dreq.den   = (s_r == 8'd1) ? 32'h0001_0000 : {prod[15:0], 16'b0};
    case (state)
      jgip_pkg::ST_SEED_A: begin
        mop.a = 32'(type_r);
        mop.b = 32'(jgip_pkg::SEED_MUL);
      end
      jgip_pkg::ST_SEED_B: begin
        mop.a = 32'(cz_r);
        mop.b = 32'(side_r);
      end
      jgip_pkg::ST_HASH_B: begin
        mop.a = hv;
        mop.b = jgip_pkg::HASH_MUL;
      end
      jgip_pkg::ST_SC_A: begin
        mop.a = 32'(d_mag);
        mop.b = 32'(h_r[2]);
      end
      jgip_pkg::ST_ROT_A: begin
        mop.a = 32'(h_r[3]);
        mop.b = jgip_pkg::ROT_LO;
      end
      jgip_pkg::ST_AX_A: begin
        mop.a = 32'(jgip_pkg::POS_MUL);
        mop.b = 32'(s_r);
      end
      jgip_pkg::ST_AX_B: begin
        mop.a = prod[31:0];
        mop.b = 32'(a_mag);
      end
      jgip_pkg::ST_AX_C: begin
        mop.a = 32'(hdev_mag);
        mop.b = 32'(sm1);
      end
      jgip_pkg::ST_AX_D: begin
        mop.a = prod[31:0];
        mop.b = 32'(jgip_pkg::JIT_MUL);
      end
      jgip_pkg::ST_AX_E: begin
        mop.a = 32'(s_r - 8'd1);
        mop.b = 32'(s_r);
      end
      jgip_pkg::ST_AX_F: dreq.start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= jgip_pkg::ST_IDLE;
      count        <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == jgip_pkg::ST_DONE && out_free) begin
        out_ch.valid <= 1'b1;
        if (!full_r) count <= count + 17'd1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      jgip_pkg::ST_IDLE: if (in_acc) begin
        type_r <= in_ch.type_index;
        side_r <= in_ch.side;
        s_r    <= s_c;
        cx_r   <= in_ch.cell_x;
        cz_r   <= in_ch.cell_z;
        smin_r <= in_ch.min_scale;
        smax_r <= in_ch.max_scale;
        full_r <= full_c;
        idx_r  <= count[15:0];
        k      <= 2'd0;
        ax     <= 1'b0;
      end
      jgip_pkg::ST_SEED_B: t0 <= prod[31:0];
      jgip_pkg::ST_SEED_C: seed <= t0 + prod[31:0] + 32'(cx_r);
      jgip_pkg::ST_HASH_A: hv <= v3;
      jgip_pkg::ST_HASH_C: begin
        h_r[k] <= v4[23:0];
        k      <= k + 2'd1;
      end
      jgip_pkg::ST_SC_B:   scale_r <= sc_sum[43] ? 18'd0 : sc_sum[41:24];
      jgip_pkg::ST_ROT_B:  rot_r <= rsum[58:40];
      jgip_pkg::ST_AX_C:   m2 <= prod[37:0];
      jgip_pkg::ST_AX_E:   jm <= prod[43:0];
      jgip_pkg::ST_AX_F:   nneg <= num_s[56];
      jgip_pkg::ST_AX_DIV: if (drsp.done) begin
        if (ax) posz_r <= nneg ? -$signed(q_sat) : $signed(q_sat);
        else    posx_r <= nneg ? -$signed(q_sat) : $signed(q_sat);
        ax <= 1'b1;
      end
      jgip_pkg::ST_DONE: if (out_free) begin
        out_ch.accepted       <= !full_r;
        out_ch.instance_index <= full_r ? 16'd0 : idx_r;
        out_ch.pos_x          <= full_r ? 22'sd0 : posx_r;
        out_ch.pos_z          <= full_r ? 22'sd0 : posz_r;
        out_ch.scale          <= full_r ? 18'd0 : scale_r;
        out_ch.rotation       <= full_r ? 19'd0 : rot_r;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/jittered_grid_instance_placer.sv
// ----------------------------------------------------------------------------
// jittered_grid_instance_placer
// Places one foliage instance per grid cell item with hashed jitter.
// ----------------------------------------------------------------------------
// One item is taken at a time. After acceptance the seed states form the
// seed, four hashes run, scale and rotation are computed on the shared
// 32x32 multiplier, each axis uses the multiplier and then a pass of the
// bit-serial divider, and the done state loads the output register. The
// input is ready again once that register is loaded, so a new item is never
// taken before the last one is through; a stalled output holds the block
// until the pending result is taken. Items that arrive with the instance
// count at capacity skip the datapath and go straight to the done state,
// which loads the result with accepted low. The capacity register sits at
// APB address 0.
module jittered_grid_instance_placer #(
  parameter int MAX_SIDE     = jgip_pkg::MAX_SIDE_DEF,
  parameter int MAX_CAPACITY = jgip_pkg::MAX_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  jgip_in_if.sink     in_ch,
  jgip_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [16:0] capacity;

  assign pready = 1'b1;
  assign prdata = (paddr == jgip_pkg::ADDR_CAPACITY) ? 32'(capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= jgip_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && paddr == jgip_pkg::ADDR_CAPACITY) begin
      capacity <= pwdata[16:0];
    end
  end

  jgip_ctrl #(
    .MAX_SIDE    (MAX_SIDE),
    .MAX_CAPACITY(MAX_CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .capacity(capacity),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

endmodule
